[rtl/uart_tx_rx_ring_buffers_macros.svh]
// Assertion macros shared by the buffered UART ring FIFO modules.
`ifndef UART_TX_RX_RING_BUFFERS_MACROS_SVH
`define UART_TX_RX_RING_BUFFERS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define URB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define URB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/urb_pkg.sv]
// Package with the opcodes and FIFO control types of the buffered UART block.
`timescale 1ns / 1ps
package urb_pkg;

  // Operation codes carried by one input beat.
  typedef enum logic [2:0] {
    OP_PUSH_TX  = 3'd0,
    OP_POP_RX   = 3'd1,
    OP_LINE_RX  = 3'd2,
    OP_TX_READY = 3'd3,
    OP_FLUSH    = 3'd4
  } opcode_t;

  // Commands from the control logic to one ring FIFO.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_ctrl_t;

  // Fill status reported by one ring FIFO.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/uart_tx_rx_ring_buffers.sv]
// Top level of the buffered UART: transmit and receive ring FIFOs with event counters.
`timescale 1ns / 1ps
// One operation is accepted at each rising edge where start is high and busy is low;
// busy is high only in the first cycle after reset. Every accepted beat yields exactly
// one result, shown for one cycle with done high in the cycle right after acceptance,
// and the receiver cannot hold it off. A new beat can be accepted in every cycle, so the
// block sustains one operation per clock: each operation makes at most one access to
// each FIFO memory, and the popped byte comes from that memory's registered read port.
// The level and counter outputs hold the state after the last accepted beat until the
// next one is accepted.
module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        rx_ready,
  input  logic        tx_empty,
  input  logic [3:0]  line_errors,
  output logic        done,
  output logic        status,
  output logic [7:0]  read_byte,
  output logic        tx_byte_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_irq_enable,
  output logic [4:0]  rx_level,
  output logic [4:0]  tx_level,
  output logic [31:0] received_count,
  output logic [31:0] sent_count,
  output logic [31:0] error_count
);
  import urb_pkg::*;

  `include "uart_tx_rx_ring_buffers_macros.svh"

  localparam int TX_LW = $clog2(TX_DEPTH + 1);
  localparam int RX_LW = $clog2(RX_DEPTH + 1);

  logic             accept;
  fifo_ctrl_t       tx_ctrl;
  fifo_ctrl_t       rx_ctrl;
  fifo_stat_t       tx_stat;
  fifo_stat_t       rx_stat;
  logic [TX_LW-1:0] tx_fill;
  logic [RX_LW-1:0] rx_fill;
  logic [31:0]      tx_fill_ext;
  logic [31:0]      rx_fill_ext;
  logic [7:0]       tx_rd_data;
  logic [7:0]       rx_rd_data;
  logic             status_next;
  logic             err_hit;
  logic             restart_needed;
  logic             restart_needed_next;
  logic             irq_enable_next;
  logic             rx_sel;
  logic             tx_sel;

  assign accept = start && !busy;

  // Decode one beat into FIFO commands, the failure status and the line error flag.
  always_comb begin
    tx_ctrl     = '0;
    rx_ctrl     = '0;
    status_next = 1'b0;
    err_hit     = 1'b0;
    if (accept) begin
      unique case (opcode)
        OP_PUSH_TX: begin
          tx_ctrl.push = !tx_stat.full;
          status_next  = tx_stat.full;
        end
        OP_POP_RX: begin
          rx_ctrl.pop = !rx_stat.empty;
          status_next = rx_stat.empty;
        end
        OP_LINE_RX: begin
          rx_ctrl.push = rx_ready && !rx_stat.full;
          err_hit      = (line_errors != 4'd0);
        end
        OP_TX_READY: begin
          tx_ctrl.pop = tx_empty && !tx_stat.empty;
          err_hit     = (line_errors != 4'd0);
        end
        OP_FLUSH: begin
          tx_ctrl.flush = 1'b1;
          rx_ctrl.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Restart flag and transmit interrupt enable.
  always_comb begin
    restart_needed_next = restart_needed;
    irq_enable_next     = tx_irq_enable;
    if (tx_ctrl.push && restart_needed) begin
      restart_needed_next = 1'b0;
      irq_enable_next     = 1'b1;
    end
    if (tx_ctrl.pop) begin
      restart_needed_next = 1'b0;
    end
    if (accept && (opcode == OP_TX_READY) && tx_empty && tx_stat.empty) begin
      restart_needed_next = 1'b1;
      irq_enable_next     = 1'b0;
    end
    if (tx_ctrl.flush) begin
      restart_needed_next = 1'b1;
    end
  end

  // Control flags, counters and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b1;
      done           <= 1'b0;
      restart_needed <= 1'b1;
      tx_irq_enable  <= 1'b0;
      received_count <= '0;
      sent_count     <= '0;
      error_count    <= '0;
    end else begin
      busy           <= 1'b0;
      done           <= accept;
      restart_needed <= restart_needed_next;
      tx_irq_enable  <= irq_enable_next;
      if (rx_ctrl.push) begin
        received_count <= received_count + 32'd1;
      end
      if (tx_ctrl.pop) begin
        sent_count <= sent_count + 32'd1;
      end
      if (err_hit) begin
        error_count <= error_count + 32'd1;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      rx_sel <= rx_ctrl.pop;
      tx_sel <= tx_ctrl.pop;
    end
  end

  assign read_byte     = rx_sel ? rx_rd_data : 8'd0;
  assign tx_byte_valid = tx_sel;
  assign tx_byte       = tx_sel ? tx_rd_data : 8'd0;

  // Levels are reported in five bits.
  assign tx_fill_ext = 32'(tx_fill);
  assign rx_fill_ext = 32'(rx_fill);
  assign tx_level    = tx_fill_ext[4:0];
  assign rx_level    = rx_fill_ext[4:0];

  urb_fifo #(
    .DEPTH (TX_DEPTH)
  ) u_tx_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tx_ctrl),
    .wr_data (data_byte),
    .stat    (tx_stat),
    .level   (tx_fill),
    .rd_data (tx_rd_data)
  );

  urb_fifo #(
    .DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (rx_ctrl),
    .wr_data (data_byte),
    .stat    (rx_stat),
    .level   (rx_fill),
    .rd_data (rx_rd_data)
  );

  `URB_ASSERT_NEXT(a_one_result, 1'b1, done == $past(accept), "result strobe lost or extra")
  `URB_ASSERT_NEXT(a_pop_empty_fails, accept && (opcode == OP_POP_RX) && rx_stat.empty,
                   status && (read_byte == 8'd0), "pop from empty FIFO not reported")
  `URB_ASSERT_NEXT(a_send_counts, tx_ctrl.pop,
                   tx_byte_valid && (sent_count == $past(sent_count) + 32'd1),
                   "handed byte not counted")
  `URB_ASSERT_NEXT(a_push_enables, tx_ctrl.push, tx_irq_enable && !status,
                   "accepted push did not enable the interrupt")

endmodule

[rtl/urb_fifo.sv]
// Ring FIFO with a synchronous memory and pointers that run modulo twice the depth.
`timescale 1ns / 1ps
module urb_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  urb_pkg::fifo_ctrl_t        ctrl,
  input  logic [7:0]                 wr_data,
  output urb_pkg::fifo_stat_t        stat,
  output logic [$clog2(DEPTH+1)-1:0] level,
  output logic [7:0]                 rd_data
);
  import urb_pkg::*;

  `include "uart_tx_rx_ring_buffers_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(2 * DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr_next;
  logic [AW-1:0] wr_slot;
  logic [AW-1:0] rd_slot;
  logic [PW:0]   diff;

  // Pointers run modulo twice the depth; the slot folds them back into the memory.
  assign wr_slot = (wr_ptr >= PW'(DEPTH)) ? AW'(wr_ptr - PW'(DEPTH)) : AW'(wr_ptr);
  assign rd_slot = (rd_ptr >= PW'(DEPTH)) ? AW'(rd_ptr - PW'(DEPTH)) : AW'(rd_ptr);
  assign wr_ptr_next = (wr_ptr == PW'(2 * DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
  assign rd_ptr_next = (rd_ptr == PW'(2 * DEPTH - 1)) ? '0 : rd_ptr + PW'(1);

  // The level is the pointer difference, corrected when the write pointer has wrapped.
  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      diff = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      diff = {1'b0, wr_ptr} + (PW+1)'(2 * DEPTH) - {1'b0, rd_ptr};
    end
  end

  assign level      = LW'(diff);
  assign stat.full  = (diff == (PW+1)'(DEPTH));
  assign stat.empty = (wr_ptr == rd_ptr);

  // Pointer update; flush empties the FIFO without touching the memory.
  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_slot] <= wr_data;
    end
    if (ctrl.pop) begin
      rd_data <= mem[rd_slot];
    end
  end

  `URB_ASSERT_NOW(a_level_bound, 1'b1, level <= LW'(DEPTH), "FIFO level above depth")
  `URB_ASSERT_NEXT(a_push_grows, ctrl.push && !ctrl.pop && !ctrl.flush,
                   level == $past(level) + LW'(1), "push did not raise the level")
  `URB_ASSERT_NEXT(a_pop_shrinks, ctrl.pop && !ctrl.push && !ctrl.flush,
                   level == $past(level) - LW'(1), "pop did not lower the level")

endmodule
